// ===== rtl/mlr_pkg.sv =====
// Package: coordinate widths, segment descriptor type and step helper for the line rasterizer.
package mlr_pkg;

	// Tile coordinate width; coordinate, pixel count and decision variable widths follow from it
	localparam int COORD_BITS = 6;
	// Decision variable width: holds +/- twice the largest major length
	localparam int DW = COORD_BITS + 3;
	// Segment queue depth, pointer width and fill count width
	localparam int QDEPTH = 2;
	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [DW-1:0] dvar_t;

	// Classified segment: start point, axis lengths and step directions
	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t major;
		coord_t minor;
		logic   y_major;
		logic   x_neg;
		logic   y_neg;
	} seg_t;

	// Move one coordinate by one pixel, wrapping within the tile
	function automatic coord_t coord_step(input coord_t c, input logic neg);
		coord_t r;
		r = neg ? (c - coord_t'(1)) : (c + coord_t'(1));
		return r;
	endfunction

endpackage

// ===== rtl/mlr_front.sv =====
// Front end: accepts segments, sorts them into zone form and pushes descriptors to the queue.
module mlr_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mlr_pkg::coord_t       x_start,
	input  mlr_pkg::coord_t       y_start,
	input  mlr_pkg::coord_t       x_end,
	input  mlr_pkg::coord_t       y_end,
	input  logic                  q_full,
	output logic                  q_push,
	output mlr_pkg::seg_t         q_wdata
);
	import mlr_pkg::*;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] dx_abs;
	logic signed [COORD_BITS:0] dy_abs;
	coord_t adx;
	coord_t ady;
	logic   y_major;

	// Take a word whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Form signed deltas and their magnitudes
	always_comb begin
		dx      = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
		dy      = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
		dx_abs  = dx[COORD_BITS] ? -dx : dx;
		dy_abs  = dy[COORD_BITS] ? -dy : dy;
		adx     = dx_abs[COORD_BITS-1:0];
		ady     = dy_abs[COORD_BITS-1:0];
		y_major = ady > adx;
	end

	// Pack the zone: major axis choice plus the sign of each delta
	always_comb begin
		q_wdata.x0      = x_start;
		q_wdata.y0      = y_start;
		q_wdata.major   = y_major ? ady : adx;
		q_wdata.minor   = y_major ? adx : ady;
		q_wdata.y_major = y_major;
		q_wdata.x_neg   = dx[COORD_BITS];
		q_wdata.y_neg   = dy[COORD_BITS];
	end

endmodule

// ===== rtl/mlr_fifo.sv =====
// Short descriptor queue between the classifier and the pixel stepper.
module mlr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mlr_pkg::seg_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output mlr_pkg::seg_t rdata
);
	import mlr_pkg::*;

	seg_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign full     = count_q == QCW'(QDEPTH);
	assign nonempty = count_q != '0;
	assign rdata    = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Hold the descriptor words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("queue fill count out of range");
`endif

endmodule

// ===== rtl/mlr_back.sv =====
// Back end: steps the midpoint decision variable and emits one pixel word per cycle while out_ready is high.
module mlr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  mlr_pkg::seg_t   q_rdata,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output mlr_pkg::coord_t pixel_x,
	output mlr_pkg::coord_t pixel_y,
	output logic            last_pixel
);
	import mlr_pkg::*;

	logic   busy_q;
	logic   out_valid_q;
	seg_t   seg_q;
	coord_t x_q;
	coord_t y_q;
	coord_t cnt_q;
	dvar_t  d_q;
	coord_t pix_x_q;
	coord_t pix_y_q;
	logic   pix_last_q;

	logic   emit;
	logic   emit_last;
	logic   step_minor;
	dvar_t  tw_major;
	dvar_t  tw_minor;
	dvar_t  d_init;
	dvar_t  d_next;

	// Emit when the output register is free or being drained
	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign emit_last = emit && (cnt_q == '0);
	assign q_pop     = q_nonempty && (!busy_q || emit_last);

	assign out_valid  = out_valid_q;
	assign pixel_x    = pix_x_q;
	assign pixel_y    = pix_y_q;
	assign last_pixel = pix_last_q;

	// Decision variable update
	always_comb begin
		tw_major   = $signed({2'b00, seg_q.major, 1'b0});
		tw_minor   = $signed({2'b00, seg_q.minor, 1'b0});
		d_init     = $signed({2'b00, q_rdata.minor, 1'b0})
		           - $signed({3'b000, q_rdata.major});
		step_minor = d_q > 0;
		d_next     = d_q + tw_minor - (step_minor ? tw_major : dvar_t'(0));
	end

	// Track segment and output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load a new segment or advance along the current one
	always_ff @(posedge clk) begin
		if (q_pop) begin
			seg_q <= q_rdata;
			x_q   <= q_rdata.x0;
			y_q   <= q_rdata.y0;
			cnt_q <= q_rdata.major;
			d_q   <= d_init;
		end else if (emit) begin
			cnt_q <= cnt_q - 1'b1;
			d_q   <= d_next;
			if (seg_q.y_major) begin
				y_q <= coord_step(y_q, seg_q.y_neg);
				if (step_minor) begin
					x_q <= coord_step(x_q, seg_q.x_neg);
				end
			end else begin
				x_q <= coord_step(x_q, seg_q.x_neg);
				if (step_minor) begin
					y_q <= coord_step(y_q, seg_q.y_neg);
				end
			end
		end
	end

	// Capture the pixel word
	always_ff @(posedge clk) begin
		if (emit) begin
			pix_x_q    <= x_q;
			pix_y_q    <= y_q;
			pix_last_q <= cnt_q == '0;
		end
	end

`ifndef ASSERT_OFF
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!busy_q || emit_last))
		else $error("segment loaded while another is in progress");
	a_stay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !emit_last) |=> busy_q)
		else $error("segment dropped before its last pixel");
	a_d_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (d_q <= tw_minor && d_q > -tw_major - dvar_t'(1)))
		else $error("decision variable out of range");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_last && !q_pop) |=> !busy_q)
		else $error("stepper still busy after last pixel");
`endif

endmodule

// ===== rtl/midpoint_line_raster.sv =====
// Top level: midpoint line rasterizer, classifier front end, queue and pixel stepper.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   x_start, y_start, x_end, y_end
//   out      out_valid / out_ready pixel_x, pixel_y, last_pixel
//
// A segment yields max(|dx|,|dy|)+1 pixel words, one per cycle from the stepper while out_ready is high.
// The stepper loads the next segment in the cycle of the previous last pixel.
// The front end classifies combinationally and takes segments while the two-entry
// queue has room, so up to two segments wait behind the one being drawn.
// Reset (arst_n low) empties the queue and the output register.
// A stalled out_ready holds the stepper; the front end keeps filling the queue.
module midpoint_line_raster (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mlr_pkg::coord_t x_start,
	input  mlr_pkg::coord_t y_start,
	input  mlr_pkg::coord_t x_end,
	input  mlr_pkg::coord_t y_end,
	output logic            out_valid,
	input  logic            out_ready,
	output mlr_pkg::coord_t pixel_x,
	output mlr_pkg::coord_t pixel_y,
	output logic            last_pixel
);
	import mlr_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_nonempty;
	seg_t q_wdata;
	seg_t q_rdata;

	// Classify incoming segments
	mlr_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// Buffer classified segments
	mlr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	// Step out pixels
	mlr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

endmodule

// ===== sim/midpoint_line_raster_tb.sv =====
// Testbench for midpoint_line_raster: predicts each segment's pixel words and checks them in order.
module midpoint_line_raster_tb;

	import mlr_pkg::*;

	// Octants of a segment, named by the standard eight-zone layout
	typedef enum logic [2:0] {
		ZONE0, ZONE1, ZONE2, ZONE3, ZONE4, ZONE5, ZONE6, ZONE7
	} zone_t;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 270;
	localparam int QUIET_ITEMS  = 40;
	localparam int DRAIN_CYCLES = 40;
	localparam int STEADY_FIRST = 20;
	localparam int STEADY_LAST  = 32;

	// Expected pixel words for every accepted segment, in emission order
	class pixel_scoreboard;
		typedef struct packed {
			coord_t x;
			coord_t y;
			logic   last;
		} pixel_t;

		pixel_t      expected[$];
		int unsigned fails;

		function new();
			fails = 0;
		endfunction

		// Rasterize one segment in zone 0 and map each pixel back to its zone
		function void note_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
			int     dx, dy, adx, ady, major, minor, d, v, ox, oy;
			zone_t  zone;
			pixel_t p;
			dx  = int'(xe) - int'(xs);
			dy  = int'(ye) - int'(ys);
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			if (adx >= ady) begin
				if (dx >= 0 && dy >= 0) zone = ZONE0;
				else if (dx < 0 && dy >= 0) zone = ZONE3;
				else if (dx < 0) zone = ZONE4;
				else zone = ZONE7;
				major = adx;
				minor = ady;
			end else begin
				if (dx >= 0 && dy >= 0) zone = ZONE1;
				else if (dx < 0 && dy >= 0) zone = ZONE2;
				else if (dx < 0) zone = ZONE5;
				else zone = ZONE6;
				major = ady;
				minor = adx;
			end
			d = 2 * minor - major;
			v = 0;
			for (int u = 0; u <= major; u++) begin
				case (zone)
					ZONE0: begin ox = u;  oy = v;  end
					ZONE1: begin ox = v;  oy = u;  end
					ZONE2: begin ox = -v; oy = u;  end
					ZONE3: begin ox = -u; oy = v;  end
					ZONE4: begin ox = -u; oy = -v; end
					ZONE5: begin ox = -v; oy = -u; end
					ZONE6: begin ox = v;  oy = -u; end
					default: begin ox = u; oy = -v; end
				endcase
				p.x    = coord_t'(int'(xs) + ox);
				p.y    = coord_t'(int'(ys) + oy);
				p.last = (u == major);
				expected.insert(expected.size(), p);
				if (d > 0) begin
					v++;
					d -= 2 * major;
				end
				d += 2 * minor;
			end
		endfunction

		// Compare one accepted pixel word with the oldest expectation
		function void check_pixel(coord_t px, coord_t py, logic last);
			pixel_t e;
			if (expected.size() == 0) begin
				$error("unexpected pixel word x=%0d y=%0d last=%0d", px, py, last);
				fails++;
				return;
			end
			e = expected.pop_front();
			if (px !== e.x) begin
				$error("pixel_x expected %0d actual %0d", e.x, px);
				fails++;
			end
			if (py !== e.y) begin
				$error("pixel_y expected %0d actual %0d", e.y, py);
				fails++;
			end
			if (last !== e.last) begin
				$error("last_pixel expected %0d actual %0d", e.last, last);
				fails++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;
	logic   out_valid;
	logic   out_ready;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last_pixel;

	pixel_scoreboard sb = new();
	int cycles = 0;
	int hold_requests = 0;
	bit quiet = 1'b0;
	bit steady = 1'b0;

	midpoint_line_raster uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Note accepted segments before checking pixel words of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_segment(x_start, y_start, x_end, y_end);
			if (out_valid && out_ready) sb.check_pixel(pixel_x, pixel_y, last_pixel);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Drive out_ready: random stall bursts, one long hold on request, none at the end
	initial begin
		int stall_left;
		int served;
		out_ready = 1'b0;
		stall_left = 0;
		served = 0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = int'($urandom_range(1, 17)) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Drop valid for a random burst now and then
	task automatic sender_gap();
		int n;
		if (quiet || steady || $urandom_range(0, 4) != 0) return;
		n = $urandom_range(1, 17);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Offer one segment word and hold it until accepted
	task automatic send_segment(input int xs, input int ys, input int xe, input int ye);
		@(negedge clk);
		in_valid <= 1'b1;
		x_start  <= coord_t'(xs);
		y_start  <= coord_t'(ys);
		x_end    <= coord_t'(xe);
		y_end    <= coord_t'(ye);
		do @(posedge clk); while (!(in_valid && in_ready));
		sender_gap();
	endtask

	// Pick a segment: mostly short ones, some across the tile, some degenerate
	task automatic random_segment(output int xs, output int ys, output int xe, output int ye);
		int kind;
		kind = $urandom_range(0, 9);
		xs = $urandom_range(0, 63);
		ys = $urandom_range(0, 63);
		if (kind < 6) begin
			xe = xs + int'($urandom_range(0, 14)) - 7;
			ye = ys + int'($urandom_range(0, 14)) - 7;
			xe = (xe < 0) ? 0 : ((xe > 63) ? 63 : xe);
			ye = (ye < 0) ? 0 : ((ye > 63) ? 63 : ye);
		end else if (kind < 9) begin
			xe = $urandom_range(0, 63);
			ye = $urandom_range(0, 63);
		end else begin
			case ($urandom_range(0, 3))
				0: begin xe = xs; ye = ys; end
				1: begin xe = $urandom_range(0, 63); ye = ys; end
				2: begin xe = xs; ye = $urandom_range(0, 63); end
				default: begin
					xe = $urandom_range(0, 63);
					ye = ys + (xe - xs);
					if (ye < 0 || ye > 63) ye = ys - (xe - xs);
					if (ye < 0 || ye > 63) ye = ys;
				end
			endcase
		end
	endtask

	// Main sequence: reset, directed segments, random segments, drain
	initial begin
		int xs, ys, xe, ye;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		x_start  = '0;
		y_start  = '0;
		x_end    = '0;
		y_end    = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// single point, full-length axis lines, full diagonals in all four ties
		send_segment(10, 10, 10, 10);
		send_segment(0, 0, 63, 0);
		send_segment(63, 63, 0, 63);
		send_segment(0, 0, 0, 63);
		send_segment(63, 63, 63, 0);
		send_segment(0, 0, 63, 63);
		send_segment(63, 0, 0, 63);
		send_segment(63, 63, 0, 0);
		send_segment(0, 63, 63, 0);
		// one segment per zone
		send_segment(5, 7, 40, 20);
		send_segment(5, 7, 20, 50);
		send_segment(40, 5, 25, 50);
		send_segment(50, 10, 8, 30);
		send_segment(50, 40, 3, 20);
		send_segment(30, 60, 20, 2);
		send_segment(10, 60, 25, 1);
		send_segment(2, 40, 60, 21);
		// shallow and tiny segments
		send_segment(0, 0, 63, 1);
		send_segment(63, 62, 0, 63);
		send_segment(32, 32, 33, 33);
		send_segment(0, 0, 1, 0);
		send_segment(63, 63, 63, 63);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// stall the receiver for a long stretch while segments keep coming
			if (i == STEADY_FIRST) begin
				hold_requests++;
				steady = 1'b1;
			end
			if (i == STEADY_LAST) steady = 1'b0;
			if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
			random_segment(xs, ys, xe, ye);
			send_segment(xs, ys, xe, ye);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then watch for stray words
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
